FILE: rtl/core/canmbx_pkg.sv
package canmbx_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int STANDARD_SLOTS = 8;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int STD_END = (STANDARD_SLOTS < SLOT_COUNT) ? STANDARD_SLOTS : SLOT_COUNT;
	localparam bit EXT_EMPTY = (STANDARD_SLOTS >= SLOT_COUNT);

	localparam int CMD_W = 3;
	localparam int IDENT_W = 29;
	localparam int HINT_W = 4;
	localparam int LEN_W = 4;
	localparam int DATA_W = 64;
	localparam int STATUS_W = 2;
	localparam int USED_W = 4;

	typedef logic [SLOT_W-1:0] slot_t;

	localparam slot_t EXT_FIRST = SLOT_W'(EXT_EMPTY ? 0 : STANDARD_SLOTS);
	localparam slot_t STD_LAST = SLOT_W'(STD_END - 1);
	localparam slot_t ALL_LAST = SLOT_W'(SLOT_COUNT - 1);

	localparam logic [CMD_W-1:0] CMD_SET_WAIT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RECEIVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FETCH = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ANSWER = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

	typedef struct packed {
		slot_t addr;
		logic cmp_zero;
		logic ident_wr;
		logic ident_clr;
		logic fresh_set;
		logic fresh_clr;
	} ctl_t;

	typedef struct packed {
		logic eq;
		logic fresh;
	} stat_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [DATA_W-1:0] bytes;
	} ram_word_t;

endpackage

FILE: rtl/core/canmbx_req_if.sv
interface canmbx_req_if import canmbx_pkg::*; ;
	logic valid;
	logic ready;
	logic [CMD_W-1:0] cmd;
	logic [IDENT_W-1:0] ident;
	logic is_extended;
	logic is_answer;
	logic [HINT_W-1:0] slot_hint;
	logic [LEN_W-1:0] dlc;
	logic [DATA_W-1:0] frame_data;

	modport source (
		output valid, cmd, ident, is_extended, is_answer, slot_hint, dlc, frame_data,
		input ready
	);
	modport sink (
		input valid, cmd, ident, is_extended, is_answer, slot_hint, dlc, frame_data,
		output ready
	);
endinterface

FILE: rtl/core/canmbx_rsp_if.sv
interface canmbx_rsp_if import canmbx_pkg::*; ;
	logic valid;
	logic ready;
	logic [STATUS_W-1:0] status;
	logic [LEN_W-1:0] out_dlc;
	logic [DATA_W-1:0] out_data;
	logic [USED_W-1:0] slot_used;

	modport source (
		output valid, status, out_dlc, out_data, slot_used,
		input ready
	);
	modport sink (
		input valid, status, out_dlc, out_data, slot_used,
		output ready
	);
endinterface

FILE: rtl/core/canmbx_ram.sv
module canmbx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/canmbx_store.sv
module canmbx_store import canmbx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ctl_t ctl,
	input logic [IDENT_W-1:0] key,
	output stat_t stat
);
	logic [IDENT_W-1:0] ident_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] fresh_q;
	logic [IDENT_W-1:0] operand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				ident_q[i] <= '0;
			end
			fresh_q <= '0;
		end else begin
			if (ctl.ident_wr) begin
				ident_q[ctl.addr] <= ctl.ident_clr ? '0 : key;
			end
			if (ctl.fresh_set) begin
				fresh_q[ctl.addr] <= 1'b1;
			end else if (ctl.fresh_clr) begin
				fresh_q[ctl.addr] <= 1'b0;
			end
		end
	end

	assign operand = ctl.cmp_zero ? '0 : key;
	assign stat.eq = (ident_q[ctl.addr] == operand);
	assign stat.fresh = fresh_q[ctl.addr];
endmodule

FILE: rtl/core/canmbx_seq.sv
module canmbx_seq import canmbx_pkg::*; (
	input logic clk,
	input logic arst_n,
	canmbx_req_if.sink req,
	canmbx_rsp_if.source rsp,
	output ctl_t ctl,
	output logic [IDENT_W-1:0] key,
	input stat_t stat,
	output logic ram_we,
	output ram_word_t ram_wdata,
	input ram_word_t ram_rdata
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_SETW,
		S_HINT,
		S_SCAN,
		S_ANSW,
		S_READ,
		S_FIN
	} state_t;

	state_t state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [IDENT_W-1:0] ident_q;
	logic ans_q;
	logic [HINT_W-1:0] hint_q;
	logic [LEN_W-1:0] dlc_q;
	logic [DATA_W-1:0] data_q;
	slot_t idx_q;
	slot_t last_q;
	slot_t answer_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [LEN_W-1:0] res_dlc_q;
	logic [DATA_W-1:0] res_data_q;
	slot_t res_slot_q;
	logic out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [LEN_W-1:0] out_dlc_q;
	logic [DATA_W-1:0] out_data_q;
	logic [USED_W-1:0] out_slot_q;
	logic hint_ok;
	logic hit;

	function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
		logic [DATA_W-1:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (LEN_W'(b) < n) begin
				m[8*b +: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.out_dlc = out_dlc_q;
	assign rsp.out_data = out_data_q;
	assign rsp.slot_used = out_slot_q;
	assign key = ident_q;
	assign hint_ok = (32'(hint_q) < 32'(SLOT_COUNT));

	always_comb begin
		ctl = '0;
		ctl.addr = idx_q;
		ctl.cmp_zero = (cmd_q == CMD_ADD);
		ram_we = 1'b0;
		ram_wdata.len = dlc_q;
		ram_wdata.bytes = data_q & byte_mask(dlc_q);
		hit = 1'b0;
		unique case (state_q)
			S_SETW: begin
				ctl.addr = '0;
				ctl.ident_wr = 1'b1;
			end
			S_HINT: begin
				ctl.addr = slot_t'(hint_q);
				hit = hint_ok && stat.eq;
			end
			S_SCAN: begin
				hit = stat.eq && ((cmd_q != CMD_FETCH) || stat.fresh);
			end
			S_ANSW: begin
				ctl.addr = answer_q;
				hit = stat.fresh;
			end
			default: begin
			end
		endcase
		if (hit) begin
			case (cmd_q)
				CMD_ADD: begin
					ctl.ident_wr = 1'b1;
				end
				CMD_REMOVE, CMD_ANSWER: begin
					ctl.ident_wr = 1'b1;
					ctl.ident_clr = 1'b1;
					ctl.fresh_clr = 1'b1;
				end
				CMD_RECEIVE: begin
					ram_we = 1'b1;
					ctl.fresh_set = 1'b1;
				end
				CMD_FETCH: begin
					ctl.fresh_clr = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			answer_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q <= req.cmd;
						ident_q <= req.ident;
						ans_q <= req.is_answer;
						hint_q <= req.slot_hint;
						dlc_q <= (req.dlc > LEN_W'(8)) ? LEN_W'(8) : req.dlc;
						data_q <= req.frame_data;
						res_dlc_q <= '0;
						res_data_q <= '0;
						res_slot_q <= '0;
						res_status_q <= ST_OK;
						idx_q <= req.is_extended ? EXT_FIRST : slot_t'(1);
						last_q <= req.is_extended ? ALL_LAST : STD_LAST;
						case (req.cmd)
							CMD_SET_WAIT: begin
								state_q <= S_SETW;
							end
							CMD_ADD, CMD_REMOVE: begin
								if (req.cmd == CMD_ADD) begin
									res_status_q <= ST_FULL;
								end
								state_q <= (req.is_extended && EXT_EMPTY) ? S_FIN : S_SCAN;
							end
							CMD_RECEIVE: begin
								res_status_q <= ST_NONE;
								idx_q <= '0;
								last_q <= ALL_LAST;
								state_q <= S_HINT;
							end
							CMD_FETCH: begin
								res_status_q <= ST_NONE;
								if (!req.is_extended) begin
									idx_q <= '0;
								end
								state_q <= (req.is_extended && EXT_EMPTY) ? S_FIN : S_SCAN;
							end
							CMD_ANSWER: begin
								res_status_q <= ST_NONE;
								state_q <= S_ANSW;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_SETW: begin
					state_q <= S_FIN;
				end
				S_HINT: begin
					if (hit) begin
						res_status_q <= ST_OK;
						res_slot_q <= ctl.addr;
						state_q <= S_FIN;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						res_status_q <= ST_OK;
						res_slot_q <= idx_q;
						if ((cmd_q == CMD_ADD) && ans_q) begin
							answer_q <= idx_q;
						end
						state_q <= (cmd_q == CMD_FETCH) ? S_READ : S_FIN;
					end else if (idx_q == last_q) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q + slot_t'(1);
					end
				end
				S_ANSW: begin
					if (hit) begin
						res_status_q <= ST_OK;
						res_slot_q <= answer_q;
						state_q <= S_READ;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_READ: begin
					res_dlc_q <= ram_rdata.len;
					res_data_q <= ram_rdata.bytes;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_status_q <= res_status_q;
						out_dlc_q <= res_dlc_q;
						out_data_q <= res_data_q;
						out_slot_q <= USED_W'(res_slot_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

FILE: rtl/core/can_receive_mailbox_table_top.sv
// Receive mailbox table for a CAN controller: one command beat in, one result beat out.
// The block takes one command at a time and holds req.ready low until that command has
// produced its result; a finished result waits in an output register, so the next command
// is taken while it is still pending. Slots are visited one per clock through a single
// identifier comparator: add, remove and fetch search the standard or extended half of the
// table, receive tries the hinted slot first and then searches all SLOT_COUNT slots, and
// fetch answer checks only the slot recorded for the answer. Frame lengths and data sit in a
// RAM with a registered read, which a fetch that finds data waits out in the S_READ state.
module can_receive_mailbox_table_top import canmbx_pkg::*; (
	input logic clk,
	input logic arst_n,
	canmbx_req_if.sink req,
	canmbx_rsp_if.source rsp
);
	ctl_t ctl;
	stat_t stat;
	logic [IDENT_W-1:0] key;
	logic ram_we;
	ram_word_t ram_wdata;
	ram_word_t ram_rdata;

	canmbx_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.ctl(ctl),
		.key(key),
		.stat(stat),
		.ram_we(ram_we),
		.ram_wdata(ram_wdata),
		.ram_rdata(ram_rdata)
	);

	canmbx_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.key(key),
		.stat(stat)
	);

	canmbx_ram #(
		.WIDTH($bits(ram_word_t)),
		.DEPTH(SLOT_COUNT)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ctl.addr),
		.wdata(ram_wdata),
		.raddr(ctl.addr),
		.rdata(ram_rdata)
	);
endmodule

FILE: rtl/core/canmbx_chk.sv
module canmbx_chk import canmbx_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [STATUS_W-1:0] status,
	input logic [LEN_W-1:0] out_dlc,
	input logic [DATA_W-1:0] out_data,
	input logic [USED_W-1:0] slot_used
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(out_dlc)
			&& $stable(out_data) && $stable(slot_used))
		else $error("Result beat changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Command accepted while the previous one is still in work.");

	a_miss_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != ST_OK) |-> (out_dlc == '0) && (out_data == '0))
		else $error("Result without data carries a length or bytes.");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (out_dlc <= LEN_W'(8)) && (status != 2'd3))
		else $error("Result length or status out of range.");
endmodule

bind can_receive_mailbox_table_top canmbx_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.status(rsp.status),
	.out_dlc(rsp.out_dlc),
	.out_data(rsp.out_data),
	.slot_used(rsp.slot_used)
);
